// ===== sv/cross_morphology_filter_assert.svh =====
// Assertion macros used by the cross morphology filter checker.
`ifndef CROSS_MORPHOLOGY_FILTER_ASSERT_SVH
`define CROSS_MORPHOLOGY_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cross_morphology_filter check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cross_morphology_filter check failed");

`endif

// ===== sv/cmf_pkg.sv =====
// Shared types, constants and helper functions of the cross morphology filter.
package cmf_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int PIX_W = 24;
    localparam int WIDTH_W = 11;
    localparam int ROW_W = 13;
    localparam int OP_W = 2;
    localparam int IDX_W = 2;
    localparam int DATA_W = 13;

    localparam logic [PIX_W-1:0] PIX_MASK = 24'hFFFFFF;
    localparam logic [PIX_W-1:0] THRESH_WORD = 24'h7F7F7F;
    localparam logic [7:0] RED_LIMIT = 8'd200;

    localparam logic [WIDTH_W-1:0] RESET_WIDTH = 11'd640;
    localparam logic [ROW_W-1:0] RESET_HEIGHT = 13'd480;

    typedef enum logic [OP_W-1:0] {
        OP_DILATE = 2'd0,
        OP_ERODE = 2'd1,
        OP_OPEN = 2'd2,
        OP_CLOSE = 2'd3
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_OPERATION = 2'd2,
        REG_BINARY = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [ROW_W-1:0] height;
        logic binary;
        logic dilate;
    } stage_cfg_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic [PIX_W-1:0] pix;
    } tok_t;

    function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic dilate);
        logic [PIX_W-1:0] res;
        if (dilate)
        begin
            res = (b > a) ? b : a;
        end
        else
        begin
            res = (b < a) ? b : a;
        end
        return res;
    endfunction

endpackage

// ===== sv/cmf_stage.sv =====
// One morphology stage: packed two-row line buffer, cross window and output word register.
module cmf_stage #(
    parameter int MAX_WIDTH = cmf_pkg::DEF_MAX_WIDTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmf_pkg::stage_cfg_t      cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_has_pixel,
    input  logic [cmf_pkg::PIX_W-1:0] in_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output cmf_pkg::tok_t            out_tok
);
    import cmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef logic [1:0][PIX_W-1:0] entry_t;

    entry_t row_mem [MAX_WIDTH];
    entry_t rd_a_reg;
    entry_t rd_b_reg;
    entry_t wdata;

    logic [CW-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] left_reg;
    logic tok_valid_reg, tok_valid_next;
    tok_t tok_reg;

    logic [WW-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [WW:0] col_p1;
    logic [CW:0] b_full;
    logic [CW-1:0] addr_a, addr_b;
    logic acc, proc, drain, wrap, emit, last, we, cur;
    logic [PIX_W-1:0] v, ctr, above, left, right, below, m1, m2, m3, ext, res;

    always_comb
    begin
        if (cfg.width == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(cfg.width) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(cfg.width);
        end
        h_eff = (cfg.height == '0) ? ROW_W'(1) : cfg.height;
    end

    assign in_ready = !tok_valid_reg || out_ready;
    assign acc = in_valid && in_ready;
    assign col_p1 = (WW + 1)'(col_reg) + (WW + 1)'(1);
    assign wrap = col_p1 >= {1'b0, w_eff};
    assign drain = row_reg >= h_eff;
    assign proc = in_has_pixel || drain;
    assign emit = proc && (row_reg != '0);
    assign last = drain && wrap;
    assign cur = row_reg[0];

    always_comb
    begin
        if (cfg.binary)
        begin
            v = (in_value < THRESH_WORD) ? '0 : PIX_MASK;
        end
        else
        begin
            v = in_value;
        end
        ctr = rd_a_reg[~cur];
        above = (row_reg == ROW_W'(1)) ? ctr : rd_a_reg[cur];
        left = (col_reg == '0) ? ctr : left_reg;
        right = wrap ? ctr : rd_b_reg[~cur];
        below = drain ? ctr : v;
        m1 = pick(ctr, above, cfg.dilate);
        m2 = pick(left, right, cfg.dilate);
        m3 = pick(m1, m2, cfg.dilate);
        ext = pick(m3, below, cfg.dilate);
        if (cfg.binary)
        begin
            res = (ext[PIX_W-1:PIX_W-8] > RED_LIMIT) ? PIX_MASK : '0;
        end
        else
        begin
            res = ext;
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc && proc)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (wrap)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = CW'(col_p1);
            end
        end
    end

    assign we = acc && in_has_pixel && !drain;

    always_comb
    begin
        wdata = rd_a_reg;
        wdata[cur] = v;
        wdata[~cur] = ctr;
    end

    assign addr_a = col_next;
    assign b_full = (CW + 1)'(col_next) + (CW + 1)'(1);
    assign addr_b = (b_full >= (CW + 1)'(MAX_WIDTH)) ? '0 : CW'(b_full);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[col_reg] <= wdata;
        end
        rd_a_reg <= (we && col_reg == addr_a) ? wdata : row_mem[addr_a];
        rd_b_reg <= (we && col_reg == addr_b) ? wdata : row_mem[addr_b];
    end

    always_comb
    begin
        tok_valid_next = tok_valid_reg;
        if (acc)
        begin
            tok_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            tok_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            tok_reg.emit <= emit;
            tok_reg.last <= proc && last;
            tok_reg.pix <= res;
        end
        if (acc && proc)
        begin
            left_reg <= ctr;
        end
    end

    assign out_valid = tok_valid_reg;
    assign out_tok = tok_reg;

endmodule

// ===== sv/cross_morphology_filter.sv =====
// Top level of the cross morphology filter: configuration registers and two cascaded stages.
// Throughput is one word per clock while the output is not stalled, set by one
// read-modify-write of each stage's line buffer. A result word is held in stage 0's output
// token for dilate and erode, then stage 1's for open and close; a stage trails by one row.
// Reset clears the configuration to 640 x 480 dilate, the positions and the valid flags.
// Line buffers are not cleared and need no clearing pass; items are taken right after reset.
module cross_morphology_filter #(
    parameter int MAX_WIDTH = cmf_pkg::DEF_MAX_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cmf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [cmf_pkg::DATA_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cmf_pkg::PIX_W-1:0]  pixel_in,
    input  logic                       is_flush,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [cmf_pkg::PIX_W-1:0]  pixel_out,
    output logic                       last_of_frame
);
    import cmf_pkg::*;

    logic [WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    op_t operation_reg;
    logic binary_reg;

    stage_cfg_t cfg0, cfg1;
    tok_t tok0, tok1;
    logic pair, s0_valid, s0_ready, s1_in_ready, s1_valid, s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            operation_reg <= OP_DILATE;
            binary_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH: width_reg <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                REG_OPERATION: operation_reg <= op_t'(cfg_data[OP_W-1:0]);
                REG_BINARY: binary_reg <= cfg_data[0];
                default: binary_reg <= binary_reg;
            endcase
        end
    end

    assign pair = (operation_reg == OP_OPEN) || (operation_reg == OP_CLOSE);

    always_comb
    begin
        cfg0.width = width_reg;
        cfg0.height = height_reg;
        cfg0.binary = binary_reg;
        cfg0.dilate = (operation_reg == OP_DILATE) || (operation_reg == OP_CLOSE);
        cfg1 = cfg0;
        cfg1.dilate = (operation_reg == OP_OPEN);
    end

    cmf_stage #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_stage0 (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg0),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_has_pixel(!is_flush),
        .in_value(pixel_in),
        .out_valid(s0_valid),
        .out_ready(s0_ready),
        .out_tok(tok0)
    );

    cmf_stage #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_stage1 (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg1),
        .in_valid(pair && s0_valid),
        .in_ready(s1_in_ready),
        .in_has_pixel(tok0.emit),
        .in_value(tok0.pix),
        .out_valid(s1_valid),
        .out_ready(s1_ready),
        .out_tok(tok1)
    );

    assign s0_ready = pair ? s1_in_ready : (!tok0.emit || out_ready);
    assign s1_ready = !tok1.emit || out_ready;
    assign out_valid = pair ? (s1_valid && tok1.emit) : (s0_valid && tok0.emit);
    assign pixel_out = pair ? tok1.pix : tok0.pix;
    assign last_of_frame = pair ? tok1.last : tok0.last;

endmodule

// ===== sv/cmf_checker.sv =====
// Port-level checker of the cross morphology filter and its bind to the top level.
`include "cross_morphology_filter_assert.svh"

module cmf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [cmf_pkg::PIX_W-1:0]  pixel_out,
    input logic                       last_of_frame
);
    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            seen_reg <= 1'b1;
        end
    end

    // A word is never shown before any item has been taken since reset.
    `CMF_ASSERT_IMP(a_no_invented_word, out_valid, seen_reg)
    // With the output side free, the whole pipeline can move and takes the next item.
    `CMF_ASSERT_IMP(a_ready_when_drained, out_ready || !out_valid, in_ready)
    `CMF_ASSERT_NXT(a_stall_holds, out_valid && !out_ready,
                    out_valid && $stable(pixel_out) && $stable(last_of_frame))

endmodule

bind cross_morphology_filter cmf_checker u_cmf_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_out(pixel_out),
    .last_of_frame(last_of_frame)
);

// ===== dv/cross_morphology_filter_tb.sv =====
// Testbench for the cross morphology filter: random frames, a scoreboard predictor and checks.
`timescale 1ns / 1ps

module cross_morphology_filter_tb;
    import cmf_pkg::*;

    typedef struct {
        logic [PIX_W-1:0] pix;
        bit last;
    } out_word_t;

    class morph_scoreboard;
        logic [WIDTH_W-1:0] width_reg;
        logic [ROW_W-1:0] height_reg;
        op_t op_reg;
        bit binary_reg;
        logic [PIX_W-1:0] line_buf[2][0:2*DEF_MAX_WIDTH-1];
        int unsigned col[2];
        int unsigned row[2];
        out_word_t expected_q[$];
        int errors;

        function new();
            width_reg = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            op_reg = OP_DILATE;
            binary_reg = 1'b0;
            col = '{0, 0};
            row = '{0, 0};
            errors = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_WIDTH: width_reg = val[WIDTH_W-1:0];
                REG_HEIGHT: height_reg = val[ROW_W-1:0];
                REG_OPERATION: op_reg = op_t'(val[OP_W-1:0]);
                REG_BINARY: binary_reg = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > DEF_MAX_WIDTH)
                return DEF_MAX_WIDTH;
            return width_reg;
        endfunction

        function bit filter_stage(int s, bit has_pix, logic [PIX_W-1:0] v_in, bit dilate,
                                  output logic [PIX_W-1:0] res, output bit last);
            int unsigned w, h, r, c, cur, prv;
            logic [PIX_W-1:0] v, ctr, ext;
            logic [PIX_W-1:0] tap[5];
            bit emit;
            w = eff_width();
            h = (height_reg == 0) ? 1 : height_reg;
            r = row[s];
            c = col[s];
            res = '0;
            last = 1'b0;
            if (!has_pix && r < h)
                return 1'b0;
            if (c >= DEF_MAX_WIDTH)
                c = DEF_MAX_WIDTH - 1;
            v = v_in;
            if (binary_reg)
                v = (v_in < THRESH_WORD) ? 24'h000000 : PIX_MASK;
            cur = (r & 1) * DEF_MAX_WIDTH;
            prv = ((r + 1) & 1) * DEF_MAX_WIDTH;
            emit = (r >= 1);
            if (emit)
            begin
                ctr = line_buf[s][prv + c];
                tap[0] = ctr;
                tap[1] = (r - 1 == 0) ? ctr : line_buf[s][cur + c];
                tap[2] = (c == 0) ? ctr : line_buf[s][prv + c - 1];
                tap[3] = (c + 1 >= w) ? ctr : line_buf[s][prv + c + 1];
                tap[4] = (r >= h) ? ctr : v;
                ext = tap[0];
                for (int k = 1; k < 5; k++)
                begin
                    if (dilate ? (tap[k] > ext) : (tap[k] < ext))
                        ext = tap[k];
                end
                if (binary_reg)
                    ext = (ext[23:16] > RED_LIMIT) ? PIX_MASK : 24'h000000;
                res = ext;
            end
            if (r < h)
                line_buf[s][cur + c] = v;
            if (r >= h && c + 1 >= w)
            begin
                r = 0;
                c = 0;
                last = 1'b1;
            end
            else if (c + 1 >= w)
            begin
                c = 0;
                r++;
            end
            else
            begin
                c++;
            end
            row[s] = r;
            col[s] = c;
            return emit;
        endfunction

        function void note_input(logic [PIX_W-1:0] pix, bit flush);
            logic [PIX_W-1:0] r1, r2;
            bit l1, l2, e1, e2;
            out_word_t wd;
            e1 = filter_stage(0, !flush, pix, op_reg == OP_DILATE || op_reg == OP_CLOSE, r1, l1);
            if (op_reg == OP_DILATE || op_reg == OP_ERODE)
            begin
                if (e1)
                begin
                    wd.pix = r1;
                    wd.last = l1;
                    expected_q.push_back(wd);
                end
            end
            else
            begin
                e2 = filter_stage(1, e1, r1, op_reg == OP_OPEN, r2, l2);
                if (e2)
                begin
                    wd.pix = r2;
                    wd.last = l2;
                    expected_q.push_back(wd);
                end
            end
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic [PIX_W-1:0] pix, logic last);
            out_word_t wd;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected word %h", pix));
                return;
            end
            wd = expected_q.pop_front();
            if (pix !== wd.pix)
                report($sformatf("pixel_out %h, predicted %h", pix, wd.pix));
            if (last !== wd.last)
                report($sformatf("last_of_frame %b, predicted %b", last, wd.last));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [PIX_W-1:0] pixel_in;
    logic is_flush;
    logic out_valid;
    logic out_ready;
    logic [PIX_W-1:0] pixel_out;
    logic last_of_frame;

    morph_scoreboard sb = new();
    int items_sent = 0;
    bit no_gaps = 1'b0;

    cross_morphology_filter i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pixel_in(pixel_in),
        .is_flush(is_flush),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pixel_out(pixel_out),
        .last_of_frame(last_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60ms;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(pixel_in, is_flush);
        if (rst_n && out_valid && out_ready)
            sb.check_result(pixel_out, last_of_frame);
    end

    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    initial
    begin
        int n;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            n = gap_len();
            out_ready <= (n == 0);
            repeat ((n == 0) ? $urandom_range(1, 12) : n) @(negedge clk);
        end
    end

    function logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return THRESH_WORD;
            3: return THRESH_WORD - 24'd1;
            4: return {8'd200, 16'($urandom)};
            5: return {8'd201, 16'($urandom)};
            default: return 24'($urandom);
        endcase
    endfunction

    task push_word(logic [PIX_W-1:0] pix, bit flush);
        int n;
        n = gap_len();
        repeat (n)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= pix;
        is_flush <= flush;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task write_reg(reg_index_t idx, logic [DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        @(negedge clk);
    endtask

    task run_frame(int unsigned w, int unsigned h, op_t op, bit bin);
        int unsigned we, he, drain;
        wait_idle();
        write_reg(REG_WIDTH, DATA_W'(w));
        write_reg(REG_HEIGHT, DATA_W'(h));
        write_reg(REG_OPERATION, DATA_W'(op));
        write_reg(REG_BINARY, DATA_W'(bin));
        we = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
        he = (h == 0) ? 1 : h;
        no_gaps = ($urandom_range(0, 4) == 0);
        for (int unsigned i = 0; i < we * he; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_word(pick_pixel(), 1'b1);
            push_word(pick_pixel(), 1'b0);
        end
        drain = (op == OP_OPEN || op == OP_CLOSE) ? 2 * we : we;
        for (int unsigned i = 0; i < drain; i++)
            push_word(pick_pixel(), !(i < we && $urandom_range(0, 9) == 0));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel_in = '0;
        is_flush = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Short frames touching each operation, the thresholds and the size corners.
        push_word(24'hFFFFFF, 1'b1);
        run_frame(3, 3, OP_DILATE, 1'b0);
        run_frame(3, 2, OP_ERODE, 1'b1);
        run_frame(0, 0, OP_OPEN, 1'b0);
        run_frame(2, 3, OP_CLOSE, 1'b1);
        run_frame(1, 1, OP_DILATE, 1'b0);
        run_frame(1, 40, OP_CLOSE, 1'b0);

        while (items_sent < 1000)
        begin
            run_frame($urandom_range(0, 3) == 0 ? $urandom_range(9, 40) : $urandom_range(1, 8),
                      $urandom_range(1, 8), op_t'($urandom_range(0, 3)), $urandom_range(0, 1));
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
